// ----- rtl/core/lchc_pkg.sv -----
// Shared constants and types for the LRU cache hit counter.
package lchc_pkg;

  localparam int WAYS_DEF     = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int CAP_W        = 5;
  localparam int HITS_W       = 16;
  localparam int CMP_W        = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

endpackage

// ----- rtl/core/lchc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lchc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lchc_scan.sv -----
// Shared key comparator that scans entries one per cycle while enabled, for hit, free slot and LRU victim.
module lchc_scan #(
  parameter int KEY_BITS = 32,
  parameter int IDX_W    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lchc_pkg::scan_ctl_t      ctl,
  input  logic [IDX_W-1:0]         idx,
  input  logic                     vld_bit,
  input  logic [KEY_BITS-1:0]      ent_key,
  input  logic [IDX_W-1:0]         ent_rank,
  input  logic [KEY_BITS-1:0]      look_key,
  input  logic [IDX_W-1:0]         vict_rank,
  output logic                     hit_found,
  output logic [IDX_W-1:0]         hit_idx,
  output logic [IDX_W-1:0]         hit_rank,
  output logic [IDX_W-1:0]         free_idx,
  output logic [IDX_W-1:0]         vict_idx,
  output logic [KEY_BITS-1:0]      vict_key
);

  import lchc_pkg::*;

  logic                hit_found_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [IDX_W-1:0]    hit_rank_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [IDX_W-1:0]    vict_idx_r;
  logic [KEY_BITS-1:0] vict_key_r;
  logic                key_eq;

  assign key_eq = vld_bit && (ent_key == look_key);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.en) begin
      if (key_eq && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= idx;
        hit_rank_r  <= ent_rank;
      end
      if (!vld_bit && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx;
      end
      if (vld_bit && (ent_rank == vict_rank)) begin
        vict_idx_r <= idx;
        vict_key_r <= ent_key;
      end
    end
  end

  assign hit_found = hit_found_r;
  assign hit_idx   = hit_idx_r;
  assign hit_rank  = hit_rank_r;
  assign free_idx  = free_idx_r;
  assign vict_idx  = vict_idx_r;
  assign vict_key  = vict_key_r;

endmodule

// ----- rtl/core/lru_cache_hit_counter.sv -----
// Top level of the fully associative LRU cache hit counter.
//
// Input channel (in_valid/in_ready) carries one access beat: in_key and in_restart.
// Result channel (out_valid/out_ready) returns one beat per access: out_hit,
// out_hit_count, out_evicted and out_evicted_key (zero unless evicted).
// cfg_we/cfg_wdata write the capacity register (0 acts as 1, above WAYS acts
// as WAYS); write it only while the block is idle.
//
// Each access scans the entry RAM twice, one entry per cycle: a lookup pass
// through a single key comparator (hit, first free entry, LRU victim) and an
// age-rank update pass. The result is registered after both passes; a new
// access is taken only once the previous result is in the output register.
// in_ready is high only while idle.
//
// Reset (rst_n low, synchronous) empties the cache, clears the hit count and
// loads capacity 16. A finished result is held in the output register while
// the receiver stalls; the block waits for it to drain before reloading.
module lru_cache_hit_counter #(
  parameter int WAYS     = lchc_pkg::WAYS_DEF,
  parameter int KEY_BITS = lchc_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [lchc_pkg::HITS_W-1:0] out_hit_count,
  output logic                        out_evicted,
  output logic [KEY_BITS-1:0]         out_evicted_key,
  input  logic                        cfg_we,
  input  logic [lchc_pkg::CAP_W-1:0]  cfg_wdata
);

  import lchc_pkg::*;

  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int WORD_W = KEY_BITS + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DRAIN,
    ST_DECIDE,
    ST_UPD,
    ST_UDRAIN,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [CAP_W-1:0]    cap_r;
  logic [WAYS-1:0]     valid_r;
  logic [CNT_W-1:0]    occ_r;
  logic [HITS_W-1:0]   hits_r;
  logic [KEY_BITS-1:0] key_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    tgt_r;
  logic                all_inc_r;
  logic                keep_key_r;
  logic [IDX_W-1:0]    limit_r;
  logic                res_hit_r;
  logic                res_ev_r;
  logic [KEY_BITS-1:0] res_ev_key_r;
  logic                out_valid_r;
  logic                out_hit_r;
  logic [HITS_W-1:0]   out_hit_count_r;
  logic                out_evicted_r;
  logic [KEY_BITS-1:0] out_evicted_key_r;

  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_we;
  logic [KEY_BITS-1:0] ent_key;
  logic [IDX_W-1:0]    ent_rank;
  logic [KEY_BITS-1:0] upd_key;
  logic [IDX_W-1:0]    upd_rank;
  logic                ent_vld;
  logic [CNT_W-1:0]    occ_m1;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    ways_ext;
  logic [CMP_W-1:0]    cap_eff;
  logic                room;
  logic                issue;
  logic                accept;
  scan_ctl_t           scan_ctl;

  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    hit_rank;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    vict_idx;
  logic [KEY_BITS-1:0] vict_key;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state_r == ST_LOOK) || (state_r == ST_UPD);

  assign ent_key  = ram_rdata[WORD_W-1:IDX_W];
  assign ent_rank = ram_rdata[IDX_W-1:0];
  assign ent_vld  = valid_r[rd_idx_r];

  assign occ_m1   = occ_r - CNT_W'(1);
  assign cap_ext  = CMP_W'(cap_r);
  assign ways_ext = CMP_W'(WAYS);
  assign cap_eff  = (cap_ext == '0) ? CMP_W'(1) :
                    ((cap_ext > ways_ext) ? ways_ext : cap_ext);
  assign room     = CMP_W'(occ_r) < cap_eff;

  assign scan_ctl.clr = accept;
  assign scan_ctl.en  = rd_vld_r && ((state_r == ST_LOOK) || (state_r == ST_DRAIN));

  assign ram_we = rd_vld_r && ((state_r == ST_UPD) || (state_r == ST_UDRAIN));

  always_comb begin
    upd_key  = ent_key;
    upd_rank = ent_rank;
    if (rd_idx_r == tgt_r) begin
      upd_rank = '0;
      if (!keep_key_r) begin
        upd_key = key_r;
      end
    end else if (ent_vld && (all_inc_r || (ent_rank < limit_r))) begin
      upd_rank = ent_rank + IDX_W'(1);
    end
  end

  assign ram_wdata = {upd_key, upd_rank};

  lchc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WAYS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx_r),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  lchc_scan #(
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .idx       (rd_idx_r),
    .vld_bit   (ent_vld),
    .ent_key   (ent_key),
    .ent_rank  (ent_rank),
    .look_key  (key_r),
    .vict_rank (occ_m1[IDX_W-1:0]),
    .hit_found (hit_found),
    .hit_idx   (hit_idx),
    .hit_rank  (hit_rank),
    .free_idx  (free_idx),
    .vict_idx  (vict_idx),
    .vict_key  (vict_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      hits_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= issue;
      rd_idx_r <= cnt_r;
      if (issue) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            key_r <= in_key;
            cnt_r <= '0;
            if (in_restart) begin
              valid_r <= '0;
              occ_r   <= '0;
              hits_r  <= '0;
            end
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (cnt_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          cnt_r        <= '0;
          res_hit_r    <= hit_found;
          res_ev_r     <= 1'b0;
          res_ev_key_r <= '0;
          if (hit_found) begin
            tgt_r      <= hit_idx;
            all_inc_r  <= 1'b0;
            keep_key_r <= 1'b1;
            limit_r    <= hit_rank;
            if (hits_r != '1) begin
              hits_r <= hits_r + HITS_W'(1);
            end
          end else if (room) begin
            tgt_r            <= free_idx;
            all_inc_r        <= 1'b1;
            keep_key_r       <= 1'b0;
            limit_r          <= '0;
            valid_r[free_idx] <= 1'b1;
            occ_r            <= occ_r + CNT_W'(1);
          end else begin
            tgt_r        <= vict_idx;
            all_inc_r    <= 1'b1;
            keep_key_r   <= 1'b0;
            limit_r      <= '0;
            res_ev_r     <= 1'b1;
            res_ev_key_r <= vict_key;
          end
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (cnt_r == LAST_IDX) begin
            state_r <= ST_UDRAIN;
          end
        end
        ST_UDRAIN: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_hit_r         <= res_hit_r;
            out_hit_count_r   <= hits_r;
            out_evicted_r     <= res_ev_r;
            out_evicted_key_r <= res_ev_key_r;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_count   = out_hit_count_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule
